// ----- design/aesr_pkg.sv -----
// ============================================================================
// aesr_pkg
// Shared types, command codes, S-box table and GF(2^8) helper for the AES
// encryption round block.
// ============================================================================
package aesr_pkg;

    typedef logic [63:0] t_half;
    typedef logic [1:0]  t_cmd;
    typedef logic [7:0]  t_byte;

    localparam int unsigned BLOCK_BYTES = 16;

    // Command codes; the unused code behaves like the add-key command
    localparam t_cmd CMD_ADD_KEY     = 2'd0;
    localparam t_cmd CMD_FULL_ROUND  = 2'd1;
    localparam t_cmd CMD_FINAL_ROUND = 2'd2;

    typedef struct packed {
        t_cmd  cmd;
        t_half state_hi;
        t_half state_lo;
        t_half key_hi;
        t_half key_lo;
    } t_in_item;

    typedef struct packed {
        t_half out_hi;
        t_half out_lo;
    } t_out_item;

    // Forward S-box
    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiply by x in GF(2^8), reduction polynomial 0x11b
    function automatic t_byte xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ----- design/aesr_if.sv -----
// ============================================================================
// aesr_if
// Valid/ready channels of the AES encryption round block: the input item
// (command, state, round key) and the result item (new state).
// ============================================================================
interface aesr_in_if;
    logic                 valid;
    logic                 ready;
    aesr_pkg::t_cmd       cmd;
    aesr_pkg::t_half      state_hi;
    aesr_pkg::t_half      state_lo;
    aesr_pkg::t_half      key_hi;
    aesr_pkg::t_half      key_lo;

    modport source (output valid, cmd, state_hi, state_lo, key_hi, key_lo, input ready);
    modport sink   (input valid, cmd, state_hi, state_lo, key_hi, key_lo, output ready);
endinterface

interface aesr_out_if;
    logic                 valid;
    logic                 ready;
    aesr_pkg::t_half      out_hi;
    aesr_pkg::t_half      out_lo;

    modport source (output valid, out_hi, out_lo, input ready);
    modport sink   (input valid, out_hi, out_lo, output ready);
endinterface

// ----- design/aesr_round.sv -----
// ============================================================================
// aesr_round
// Combinational round transform: SubBytes, ShiftRows, MixColumns and
// AddRoundKey, selected by the item's command.
// ============================================================================
module aesr_round (
    input  aesr_pkg::t_in_item  i_item,
    output aesr_pkg::t_out_item o_item
);
    import aesr_pkg::*;

    t_byte w_st  [BLOCK_BYTES];
    t_byte w_key [BLOCK_BYTES];
    t_byte w_ss  [BLOCK_BYTES];
    t_byte w_mix [BLOCK_BYTES];
    t_byte w_pre [BLOCK_BYTES];
    t_byte w_res [BLOCK_BYTES];

    // Unpack halves into bytes, byte 0 in the top bits of the high half
    always_comb begin
        for (int n = 0; n < 8; n++) begin
            w_st[n]      = i_item.state_hi[63 - 8*n -: 8];
            w_st[n + 8]  = i_item.state_lo[63 - 8*n -: 8];
            w_key[n]     = i_item.key_hi[63 - 8*n -: 8];
            w_key[n + 8] = i_item.key_lo[63 - 8*n -: 8];
        end
    end

    // Substitute and shift rows: row r of column c takes column c+r
    always_comb begin
        for (int col = 0; col < 4; col++) begin
            for (int row = 0; row < 4; row++) begin
                w_ss[col*4 + row] = SBOX[w_st[((col + row) % 4) * 4 + row]];
            end
        end
    end

    // Mix each column
    always_comb begin
        for (int col = 0; col < 4; col++) begin
            w_mix[col*4 + 0] = xtime(w_ss[col*4 + 0]) ^ xtime(w_ss[col*4 + 1])
                             ^ w_ss[col*4 + 1] ^ w_ss[col*4 + 2] ^ w_ss[col*4 + 3];
            w_mix[col*4 + 1] = w_ss[col*4 + 0] ^ xtime(w_ss[col*4 + 1])
                             ^ xtime(w_ss[col*4 + 2]) ^ w_ss[col*4 + 2] ^ w_ss[col*4 + 3];
            w_mix[col*4 + 2] = w_ss[col*4 + 0] ^ w_ss[col*4 + 1]
                             ^ xtime(w_ss[col*4 + 2]) ^ xtime(w_ss[col*4 + 3])
                             ^ w_ss[col*4 + 3];
            w_mix[col*4 + 3] = xtime(w_ss[col*4 + 0]) ^ w_ss[col*4 + 0]
                             ^ w_ss[col*4 + 1] ^ w_ss[col*4 + 2] ^ xtime(w_ss[col*4 + 3]);
        end
    end

    // Select the transform path; the unused code adds the key only
    always_comb begin
        for (int n = 0; n < BLOCK_BYTES; n++) begin
            case (i_item.cmd)
                CMD_FULL_ROUND:  w_pre[n] = w_mix[n];
                CMD_FINAL_ROUND: w_pre[n] = w_ss[n];
                CMD_ADD_KEY:     w_pre[n] = w_st[n];
                default:         w_pre[n] = w_st[n];
            endcase
        end
    end

    // Add the round key and pack
    always_comb begin
        for (int n = 0; n < BLOCK_BYTES; n++) begin
            w_res[n] = w_pre[n] ^ w_key[n];
        end
        for (int n = 0; n < 8; n++) begin
            o_item.out_hi[63 - 8*n -: 8] = w_res[n];
            o_item.out_lo[63 - 8*n -: 8] = w_res[n + 8];
        end
    end

endmodule

// ----- design/aes_encrypt_round_top.sv -----
// ============================================================================
// aes_encrypt_round_top
// One AES-128 encryption round (add key, full round or final round) on a
// 128-bit state with valid/ready channels.
// ============================================================================
// The block takes one item per clock unless back-pressure stalls it: the item
// is captured in an input register, goes through the round logic (sixteen
// parallel S-box lookups, MixColumns and the key XOR) in one pass, and lands
// in the result register. While a result waits, one more item is still
// accepted into the input register; after that the input stalls until the
// result is taken, so under back-pressure up to two items are held inside.
module aes_encrypt_round_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aesr_in_if.sink     i_in,
    aesr_out_if.source  o_res
);
    import aesr_pkg::*;

    logic      r_s1_valid;
    logic      n_s1_valid;
    t_in_item  r_s1;
    t_in_item  n_s1;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    t_out_item w_round;
    logic      w_s1_ready;
    logic      w_s2_ready;

    // Ready when the stage ahead is empty or drains this cycle
    assign w_s2_ready = !r_out_valid || o_res.ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign i_in.ready = w_s1_ready;

    // Gather the input item
    assign n_s1.cmd      = i_in.cmd;
    assign n_s1.state_hi = i_in.state_hi;
    assign n_s1.state_lo = i_in.state_lo;
    assign n_s1.key_hi   = i_in.key_hi;
    assign n_s1.key_lo   = i_in.key_lo;

    // Next valid flags: advance when the downstream side takes
    assign n_s1_valid  = w_s1_ready ? i_in.valid : r_s1_valid;
    assign n_out_valid = w_s2_ready ? r_s1_valid : r_out_valid;

    // Round logic between the two registers
    aesr_round u_round (
        .i_item (r_s1),
        .o_item (w_round)
    );

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture payloads on transfer
    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_s1_ready) begin
            r_s1 <= n_s1;
        end
        if (r_s1_valid && w_s2_ready) begin
            r_out <= w_round;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.out_hi = r_out.out_hi;
    assign o_res.out_lo = r_out.out_lo;

    // A captured item moves to the result register when it has room
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_s2_ready) |=> r_out_valid)
        else $error("captured item did not reach the result register");

    // Add-key items come out as state XOR key
    a_add_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_s2_ready && r_s1.cmd == CMD_ADD_KEY)
        |=> (r_out.out_hi == $past(r_s1.state_hi ^ r_s1.key_hi))
            && (r_out.out_lo == $past(r_s1.state_lo ^ r_s1.key_lo)))
        else $error("add-key result mismatch");

    // Reset empties both stages
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !r_out_valid))
        else $error("stages not empty after reset");

endmodule

// ----- bench/aes_encrypt_round_checker.sv -----
// ============================================================================
// aes_encrypt_round_checker
// Watches both channels of the AES round block. For each accepted item it
// computes the new state on its own (S-box, row shift, column mix, key
// XOR), queues it, and compares every accepted result with the oldest
// queued state, half by half.
// ============================================================================
module aes_encrypt_round_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    aesr_in_if   i_in,
    aesr_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import aesr_pkg::*;

    localparam t_byte GF_REDUCE = 8'h1b;

    // Forward substitution table (FIPS-197)
    localparam t_byte AES_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // New states still owed by the block, oldest first
    t_out_item next_states_q [$];

    // Double a field element, folding the carry back with the AES polynomial
    function automatic t_byte gf_double(input t_byte a);
        return (a << 1) ^ (a[7] ? GF_REDUCE : 8'h00);
    endfunction

    // Compute the state after one round transform selected by the command
    function automatic t_out_item encrypt_round(input t_in_item it);
        t_byte     st [16];
        t_byte     rk [16];
        t_byte     tmp [16];
        t_byte     a0, a1, a2, a3;
        t_out_item res;
        int        n, col, row;
        for (n = 0; n < 8; n++) begin
            st[n]     = it.state_hi[63 - 8*n -: 8];
            st[n + 8] = it.state_lo[63 - 8*n -: 8];
            rk[n]     = it.key_hi[63 - 8*n -: 8];
            rk[n + 8] = it.key_lo[63 - 8*n -: 8];
        end
        // Substitute and rotate row r left by r columns; other codes skip this
        if (it.cmd == CMD_FULL_ROUND || it.cmd == CMD_FINAL_ROUND) begin
            for (col = 0; col < 4; col++)
                for (row = 0; row < 4; row++)
                    tmp[col*4 + row] = AES_SBOX[st[((col + row) % 4)*4 + row]];
            st = tmp;
            // Mix each column, full rounds only
            if (it.cmd == CMD_FULL_ROUND) begin
                for (col = 0; col < 4; col++) begin
                    a0 = st[col*4];
                    a1 = st[col*4 + 1];
                    a2 = st[col*4 + 2];
                    a3 = st[col*4 + 3];
                    st[col*4]     = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
                    st[col*4 + 1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
                    st[col*4 + 2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
                    st[col*4 + 3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
                end
            end
        end
        // Add the round key and repack
        for (n = 0; n < 8; n++) begin
            res.out_hi[63 - 8*n -: 8] = st[n] ^ rk[n];
            res.out_lo[63 - 8*n -: 8] = st[n + 8] ^ rk[n + 8];
        end
        return res;
    endfunction

    // Queue a prediction per accepted item, check each accepted result
    always @(posedge i_clk) begin : watch
        t_in_item  taken;
        t_out_item want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                taken.cmd      = i_in.cmd;
                taken.state_hi = i_in.state_hi;
                taken.state_lo = i_in.state_lo;
                taken.key_hi   = i_in.key_hi;
                taken.key_lo   = i_in.key_lo;
                next_states_q = {next_states_q, encrypt_round(taken)};
            end
            if (i_res.valid && i_res.ready) begin
                if (next_states_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result %h_%h with none expected",
                             $time, i_res.out_hi, i_res.out_lo);
                end else begin
                    want = next_states_q.pop_front();
                    o_checked++;
                    if (i_res.out_hi !== want.out_hi) begin
                        o_fail_count++;
                        $display("%0t: out_hi expected %h got %h",
                                 $time, want.out_hi, i_res.out_hi);
                    end
                    if (i_res.out_lo !== want.out_lo) begin
                        o_fail_count++;
                        $display("%0t: out_lo expected %h got %h",
                                 $time, want.out_lo, i_res.out_lo);
                    end
                end
            end
            o_pending = next_states_q.size();
        end
    end

endmodule

// ----- bench/aes_encrypt_round_top_tb.sv -----
// ============================================================================
// aes_encrypt_round_top_tb
// Drives the AES round block with directed corner items and then random
// items over every command, under varying idle and stall patterns, and
// takes the verdict from the checker beside it.
// ============================================================================
module aes_encrypt_round_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aesr_pkg::*;

    localparam t_cmd CMD_SPARE    = 2'd3;
    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   HOLD_CYCLES  = 80;
    localparam int   DRAIN_CYCLES = 8;
    localparam int   PHASE_ITEMS  = 645;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int send_idle_pct = 24;
    int recv_idle_pct = 58;
    int hold_gen      = 0;
    int fail_count;
    int pending;
    int checked;
    int cmd_seen [4];

    aesr_in_if  in_ch ();
    aesr_out_if res_ch ();

    aes_encrypt_round_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    aes_encrypt_round_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #1 i_clk = ~i_clk;

    // Stop a hung run
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // Drive result ready: random stalls, plus a long hold on each new request
    initial begin : receiver
        int held_gen;
        int hold_left;
        held_gen = 0;
        hold_left = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_gen != held_gen) begin
                held_gen = hold_gen;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready = 1'b0;
            end else begin
                res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic offer_item(input t_cmd cmd, input t_half sh, input t_half sl,
                              input t_half kh, input t_half kl);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.cmd      = cmd;
        in_ch.state_hi = sh;
        in_ch.state_lo = sl;
        in_ch.key_hi   = kh;
        in_ch.key_lo   = kl;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        cmd_seen[cmd]++;
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Random half: mostly uniform, sometimes built from boundary bytes
    function automatic t_half rand_half();
        t_half v;
        int    n;
        v = {$urandom, $urandom};
        if ($urandom_range(7) == 0) begin
            for (n = 0; n < 8; n++) begin
                case ($urandom_range(4))
                    0:       v[8*n +: 8] = 8'h00;
                    1:       v[8*n +: 8] = 8'hff;
                    2:       v[8*n +: 8] = 8'h80;
                    3:       v[8*n +: 8] = 8'h7f;
                    default: ;
                endcase
            end
        end
        return v;
    endfunction

    // Run a block of random items under one idle pattern, with a long hold midway
    task automatic run_phase(input int count, input int s_pct, input int r_pct);
        int   i;
        t_cmd cmd;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (i = 0; i < count; i++) begin
            if (i == count / 2)
                hold_gen++;
            case ($urandom_range(9))
                0, 1, 2: cmd = CMD_ADD_KEY;
                3, 4, 5: cmd = CMD_FULL_ROUND;
                6, 7, 8: cmd = CMD_FINAL_ROUND;
                default: cmd = CMD_SPARE;
            endcase
            offer_item(cmd, rand_half(), rand_half(), rand_half(), rand_half());
        end
    endtask

    // Reset, directed corners, three random phases, drain and verdict
    initial begin : stimulus
        in_ch.valid    = 1'b0;
        in_ch.cmd      = CMD_ADD_KEY;
        in_ch.state_hi = '0;
        in_ch.state_lo = '0;
        in_ch.key_hi   = '0;
        in_ch.key_lo   = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // All-zero and all-one state and key under every command (the spare-code all-one item has a zero high key half)
        offer_item(CMD_ADD_KEY, '0, '0, '0, '0);
        offer_item(CMD_FULL_ROUND, '0, '0, '0, '0);
        offer_item(CMD_FINAL_ROUND, '0, '0, '0, '0);
        offer_item(CMD_SPARE, '0, '0, '0, '0);
        offer_item(CMD_ADD_KEY, '1, '1, '1, '1);
        offer_item(CMD_FULL_ROUND, '1, '1, '1, '1);
        offer_item(CMD_FINAL_ROUND, '1, '1, '1, '1);
        offer_item(CMD_SPARE, '1, '1, '0, '1);
        // Standard first round of the FIPS-197 worked example
        offer_item(CMD_FULL_ROUND, 64'h193de3bea0f4e22b, 64'h9ac68d2ae9f84808,
                   64'ha0fafe1788542cb1, 64'h23a339392a6c7605);
        // Top bits set in every byte to force the field reduction, then a state with them clear
        offer_item(CMD_FULL_ROUND, {8{8'h80}}, {8{8'hff}}, '0, '0);
        offer_item(CMD_FULL_ROUND, {8{8'h7f}}, {8{8'h52}}, '1, '0);
        offer_item(CMD_FINAL_ROUND, 64'h0123456789abcdef, 64'hfedcba9876543210,
                   64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        offer_item(CMD_SPARE, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
                   64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0);
        wait_drained();

        run_phase(PHASE_ITEMS, 24, 58);
        wait_drained();
        run_phase(PHASE_ITEMS, 58, 24);
        wait_drained();
        run_phase(PHASE_ITEMS, 0, 0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Checked %0d results: %0d add-key, %0d full, %0d final, %0d spare-code",
                 checked, cmd_seen[CMD_ADD_KEY], cmd_seen[CMD_FULL_ROUND],
                 cmd_seen[CMD_FINAL_ROUND], cmd_seen[CMD_SPARE]);
        $display("Idle mixes on both sides, long result holds and full drains included");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/aesr_pkg.sv
design/aesr_if.sv
design/aesr_round.sv
design/aes_encrypt_round_top.sv
bench/aes_encrypt_round_checker.sv
bench/aes_encrypt_round_top_tb.sv
